FILE: design/mspp_pkg.sv
// shared types, constants and helpers for the motor speed pid pwm core
package mspp_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BOUND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_ACTIVE_LOW = 3'd7;

    localparam logic [15:0] LOOP_PERIOD_RESET    = 16'd655;
    localparam logic [30:0] INTEGRAL_BOUND_RESET = 31'd65536;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [23:0] speed_scale;
        logic [15:0] loop_period;
        logic [30:0] integral_bound;
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
        logic [15:0] pwm_period;
        logic        direction_active_low;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: design/mspp_cfg.sv
// configuration register file
module mspp_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [mspp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mspp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              cfg_ready,
    output mspp_pkg::cfg_t                    cfg
);

    mspp_pkg::cfg_t cfg_reg;
    mspp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mspp_pkg::REG_SPEED_SCALE:    cfg_next.speed_scale = cfg_data[23:0];
                mspp_pkg::REG_LOOP_PERIOD:    cfg_next.loop_period = cfg_data[15:0];
                mspp_pkg::REG_INTEGRAL_BOUND: cfg_next.integral_bound = cfg_data[30:0];
                mspp_pkg::REG_GAIN_P:         cfg_next.gain_p = cfg_data[23:0];
                mspp_pkg::REG_GAIN_I:         cfg_next.gain_i = cfg_data[23:0];
                mspp_pkg::REG_GAIN_D:         cfg_next.gain_d = cfg_data[23:0];
                mspp_pkg::REG_PWM_PERIOD:     cfg_next.pwm_period = cfg_data[15:0];
                mspp_pkg::REG_DIR_ACTIVE_LOW: cfg_next.direction_active_low = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                      <= '0;
            cfg_reg.loop_period          <= mspp_pkg::LOOP_PERIOD_RESET;
            cfg_reg.integral_bound       <= mspp_pkg::INTEGRAL_BOUND_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: design/mspp_mul.sv
// shared signed multiplier with registered product
module mspp_mul
(
    input  logic                                  clk,
    input  logic signed [mspp_pkg::MUL_A_W-1:0]   mul_a,
    input  logic signed [mspp_pkg::MUL_B_W-1:0]   mul_b,
    output logic signed [mspp_pkg::PROD_W-1:0]    prod
);

    logic signed [mspp_pkg::PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

FILE: design/mspp_ctrl.sv
// control sequencer and datapath around the shared multiplier
module mspp_ctrl
#(
    parameter int FRACTION_BITS = mspp_pkg::FRACTION_BITS_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mspp_pkg::cfg_t                        cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [15:0]                    encoder_count,
    input  logic signed [31:0]                    speed_setpoint,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [15:0]                           pwm_compare,
    output logic                                  direction_level,
    output logic signed [31:0]                    measured_speed,
    output logic signed [mspp_pkg::MUL_A_W-1:0]   mul_a,
    output logic signed [mspp_pkg::MUL_B_W-1:0]   mul_b,
    input  logic signed [mspp_pkg::PROD_W-1:0]    prod
);

    localparam int A_W   = mspp_pkg::MUL_A_W;
    localparam int B_W   = mspp_pkg::MUL_B_W;
    localparam int MAG_W = 2 * FRACTION_BITS + 1;
    localparam int LO_W  = (MAG_W + 1) / 2;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int ACC_W = (2 * FRACTION_BITS + 18 > 60) ? 2 * FRACTION_BITS + 18 : 60;

    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(1) <<< (2 * FRACTION_BITS);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MEAS_MUL = 4'd1;
    localparam logic [3:0] S_MEAS     = 4'd2;
    localparam logic [3:0] S_ERR      = 4'd3;
    localparam logic [3:0] S_INT_MUL  = 4'd4;
    localparam logic [3:0] S_INT      = 4'd5;
    localparam logic [3:0] S_P        = 4'd6;
    localparam logic [3:0] S_I        = 4'd7;
    localparam logic [3:0] S_D        = 4'd8;
    localparam logic [3:0] S_LIM      = 4'd9;
    localparam logic [3:0] S_HI_MUL   = 4'd10;
    localparam logic [3:0] S_HI       = 4'd11;
    localparam logic [3:0] S_LO       = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0]               state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     direction_held_reg, direction_held_next;
    logic signed [31:0]       integral_sum_reg, integral_sum_next;
    logic signed [31:0]       previous_error_reg, previous_error_next;

    logic signed [15:0]       cnt_reg, cnt_next;
    logic signed [31:0]       tgt_reg, tgt_next;
    logic signed [31:0]       meas_reg, meas_next;
    logic signed [31:0]       err_reg, err_next;
    logic signed [32:0]       deriv_reg, deriv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [15:0]              pwm_compare_reg, pwm_compare_next;
    logic                     direction_level_reg, direction_level_next;
    logic signed [31:0]       measured_speed_reg, measured_speed_next;

    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [32:0]       err_wide;
    logic signed [31:0]       err_sat;
    logic signed [31:0]       int_step;
    logic signed [33:0]       int_sum;
    logic signed [33:0]       bound_pos;
    logic signed [31:0]       int_clamped;
    logic signed [ACC_W-1:0]  lim;
    logic signed [ACC_W-1:0]  mag_full;
    logic [HI_W-1:0]          mag_hi;
    logic [LO_W-1:0]          mag_lo;
    logic                     out_free;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign pwm_compare     = pwm_compare_reg;
    assign direction_level = direction_level_reg;
    assign measured_speed  = measured_speed_reg;

    assign prod_ext  = ACC_W'(prod);
    assign err_wide  = 33'(tgt_reg) - 33'(meas_reg);
    assign err_sat   = mspp_pkg::sat32(64'(err_wide));
    assign int_step  = prod[47:16];
    assign int_sum   = 34'(integral_sum_reg) + 34'(int_step);
    assign bound_pos = signed'({3'b000, cfg.integral_bound});
    assign mag_hi    = mag_reg[MAG_W-1:LO_W];
    assign mag_lo    = mag_reg[LO_W-1:0];
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (int_sum > bound_pos)
            int_clamped = bound_pos[31:0];
        else if (int_sum < -bound_pos)
            int_clamped = 32'(-bound_pos);
        else
            int_clamped = int_sum[31:0];
    end

    always_comb
    begin
        if (acc_reg > LIM_POS)
            lim = LIM_POS;
        else if (acc_reg < LIM_NEG)
            lim = LIM_NEG;
        else
            lim = acc_reg;
        mag_full = (lim < 0) ? -lim : lim;
    end

    // multiplier operand select per sequencer step
    always_comb
    begin
        unique case (state_reg)
            S_MEAS_MUL:
            begin
                mul_a = A_W'(cnt_reg);
                mul_b = B_W'(signed'(cfg.speed_scale));
            end
            S_INT_MUL:
            begin
                mul_a = A_W'(err_reg);
                mul_b = signed'(B_W'(cfg.loop_period));
            end
            S_INT:
            begin
                mul_a = A_W'(err_reg);
                mul_b = signed'(B_W'(cfg.gain_p));
            end
            S_P:
            begin
                mul_a = A_W'(integral_sum_reg);
                mul_b = signed'(B_W'(cfg.gain_i));
            end
            S_I:
            begin
                mul_a = A_W'(deriv_reg);
                mul_b = signed'(B_W'(cfg.gain_d));
            end
            S_HI_MUL:
            begin
                mul_a = signed'(A_W'(mag_hi));
                mul_b = signed'(B_W'(cfg.pwm_period));
            end
            S_HI:
            begin
                mul_a = signed'(A_W'(mag_lo));
                mul_b = signed'(B_W'(cfg.pwm_period));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next           = state_reg;
        out_valid_next       = out_valid_reg;
        direction_held_next  = direction_held_reg;
        integral_sum_next    = integral_sum_reg;
        previous_error_next  = previous_error_reg;
        cnt_next             = cnt_reg;
        tgt_next             = tgt_reg;
        meas_next            = meas_reg;
        err_next             = err_reg;
        deriv_next           = deriv_reg;
        acc_next             = acc_reg;
        mag_next             = mag_reg;
        pwm_compare_next     = pwm_compare_reg;
        direction_level_next = direction_level_reg;
        measured_speed_next  = measured_speed_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next   = encoder_count;
                    tgt_next   = speed_setpoint;
                    state_next = S_MEAS_MUL;
                end
            end
            S_MEAS_MUL:
                state_next = S_MEAS;
            S_MEAS:
            begin
                meas_next  = mspp_pkg::sat32(64'(prod));
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next            = err_sat;
                deriv_next          = 33'(err_sat) - 33'(previous_error_reg);
                previous_error_next = err_sat;
                state_next          = S_INT_MUL;
            end
            S_INT_MUL:
                state_next = S_INT;
            S_INT:
            begin
                integral_sum_next = int_clamped;
                state_next        = S_P;
            end
            S_P:
            begin
                acc_next   = prod_ext;
                state_next = S_I;
            end
            S_I:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = S_D;
            end
            S_D:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = S_LIM;
            end
            S_LIM:
            begin
                mag_next = mag_full[MAG_W-1:0];
                if (lim > 0)
                    direction_held_next = !cfg.direction_active_low;
                else if (lim < 0)
                    direction_held_next = cfg.direction_active_low;
                state_next = S_HI_MUL;
            end
            S_HI_MUL:
                state_next = S_HI;
            S_HI:
            begin
                acc_next   = prod_ext;
                state_next = S_LO;
            end
            S_LO:
            begin
                acc_next   = (acc_reg <<< LO_W) + prod_ext;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    pwm_compare_next     = acc_reg[2*FRACTION_BITS +: 16];
                    direction_level_next = direction_held_reg;
                    measured_speed_next  = meas_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            direction_held_reg <= 1'b0;
            integral_sum_reg   <= '0;
            previous_error_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            direction_held_reg <= direction_held_next;
            integral_sum_reg   <= integral_sum_next;
            previous_error_reg <= previous_error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg             <= cnt_next;
        tgt_reg             <= tgt_next;
        meas_reg            <= meas_next;
        err_reg             <= err_next;
        deriv_reg           <= deriv_next;
        acc_reg             <= acc_next;
        mag_reg             <= mag_next;
        pwm_compare_reg     <= pwm_compare_next;
        direction_level_reg <= direction_level_next;
        measured_speed_reg  <= measured_speed_next;
    end

endmodule

FILE: design/motor_speed_pid_pwm_core.sv
// top level of the motor speed pid controller with pwm compare output
// One control tick runs from acceptance to the result word through the
// seven products (count times scale, error times loop period, the three gain
// terms, and the two halves of drive magnitude times pwm period) run one after
// another through a single 34x25 signed multiplier under a small sequencer.
// The input is not ready while a tick is in progress; the block is ready for
// the next word as soon as the result is registered, so it takes no new tick
// before the last one is through, and it holds in its last step only if the
// previous result word has not yet been taken. Configuration is always ready;
// a write is registered and used by all later steps, even of a running tick.
module motor_speed_pid_pwm_core
#(
    parameter int FRACTION_BITS = mspp_pkg::FRACTION_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mspp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mspp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [15:0]                   encoder_count,
    input  logic signed [31:0]                   speed_setpoint,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [15:0]                          pwm_compare,
    output logic                                 direction_level,
    output logic signed [31:0]                   measured_speed
);

    mspp_pkg::cfg_t                         cfg;
    logic signed [mspp_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [mspp_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [mspp_pkg::PROD_W-1:0]     prod;

    mspp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    mspp_mul u_mul
    (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    mspp_ctrl
    #(
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .encoder_count   (encoder_count),
        .speed_setpoint  (speed_setpoint),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pwm_compare     (pwm_compare),
        .direction_level (direction_level),
        .measured_speed  (measured_speed),
        .mul_a           (mul_a),
        .mul_b           (mul_b),
        .prod            (prod)
    );

endmodule

FILE: design/mspp_checker.sv
// port-level checker for the motor speed pid core, with its bind
module mspp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [15:0]         pwm_compare,
    input logic                direction_level,
    input logic signed [31:0]  measured_speed
);

    // input stays busy after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input ready too soon after accept");

    // input ready only drops on an accepted word
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without accept");

    // a new result appears only as the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result word raised while busy");

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pwm_compare)
            && $stable(direction_level) && $stable(measured_speed))
        else $error("stalled result word changed");

endmodule

bind motor_speed_pid_pwm_core mspp_checker u_mspp_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pwm_compare     (pwm_compare),
    .direction_level (direction_level),
    .measured_speed  (measured_speed)
);

FILE: tb/testbench.sv
// self-checking testbench for the motor speed pid controller with pwm compare output
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB          = mspp_pkg::FRACTION_BITS_DEFAULT;
    localparam int GAP_MAX     = 11;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;

    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [15:0]        compare;
        logic               direction;
        logic signed [31:0] speed;
    } drive_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mspp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mspp_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic signed [15:0]              encoder_count;
    logic signed [31:0]              speed_setpoint;
    logic                            out_valid;
    logic                            out_ready;
    logic [15:0]                     pwm_compare;
    logic                            direction_level;
    logic signed [31:0]              measured_speed;

    motor_speed_pid_pwm_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .encoder_count   (encoder_count),
        .speed_setpoint  (speed_setpoint),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pwm_compare     (pwm_compare),
        .direction_level (direction_level),
        .measured_speed  (measured_speed)
    );

    // controller register mirror
    logic signed [23:0] m_speed_scale    = '0;
    logic [15:0]        m_loop_period    = mspp_pkg::LOOP_PERIOD_RESET;
    logic [30:0]        m_integral_bound = mspp_pkg::INTEGRAL_BOUND_RESET;
    logic [23:0]        m_gain_p         = '0;
    logic [23:0]        m_gain_i         = '0;
    logic [23:0]        m_gain_d         = '0;
    logic [15:0]        m_pwm_period     = '0;
    logic               m_dir_active_low = 1'b0;

    // controller state mirror
    longint integral_acc   = 0;
    longint last_error     = 0;
    logic   held_direction = 1'b0;

    drive_word_t expected_drive[$];
    drive_word_t exp_word;
    int          mismatch_count = 0;
    bit          no_gaps = 1'b0;
    int          rx_hold = 0;

    always #5 clk = ~clk;

    function automatic longint clip32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    function automatic drive_word_t compute_drive(logic signed [15:0] count,
                                                  logic signed [31:0] target);
        longint c, t, scale, lp, bound, gp, gi, gd, pp;
        longint meas, err, integ, deriv, sum, lim, mag, cmp;
        logic level;
        drive_word_t w;
        c     = count;
        t     = target;
        scale = m_speed_scale;
        lp    = m_loop_period;
        bound = m_integral_bound;
        gp    = m_gain_p;
        gi    = m_gain_i;
        gd    = m_gain_d;
        pp    = m_pwm_period;
        meas  = clip32(c * scale);
        err   = clip32(t - meas);
        integ = integral_acc + ((err * lp) >>> 16);
        if (integ > bound)
            integ = bound;
        else if (integ < -bound)
            integ = -bound;
        integral_acc = integ;
        deriv = err - last_error;
        last_error = err;
        sum = gp * err + gi * integ + gd * deriv;
        lim = longint'(1) << (2 * FB);
        if (sum > lim)
            sum = lim;
        else if (sum < -lim)
            sum = -lim;
        if (sum > 0)
        begin
            level = !m_dir_active_low;
            mag = sum;
        end
        else if (sum < 0)
        begin
            level = m_dir_active_low;
            mag = -sum;
        end
        else
        begin
            level = held_direction;
            mag = 0;
        end
        held_direction = level;
        cmp = (mag * pp) >> (2 * FB);
        w.compare   = cmp[15:0];
        w.direction = level;
        w.speed     = meas[31:0];
        return w;
    endfunction

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [31:0] spread(int w);
        return $urandom() >> (32 - $urandom_range(1, w));
    endfunction

    function automatic longint signed_spread(int w);
        longint v;
        v = spread(w);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic send_tick(input logic signed [15:0] count,
                             input logic signed [31:0] target, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        encoder_count  <= count;
        speed_setpoint <= target;
        do @(posedge clk); while (!in_ready);
        expected_drive.push_back(compute_drive(count, target));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_drive.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mspp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            mspp_pkg::REG_SPEED_SCALE:    m_speed_scale    = data[23:0];
            mspp_pkg::REG_LOOP_PERIOD:    m_loop_period    = data[15:0];
            mspp_pkg::REG_INTEGRAL_BOUND: m_integral_bound = data[30:0];
            mspp_pkg::REG_GAIN_P:         m_gain_p         = data[23:0];
            mspp_pkg::REG_GAIN_I:         m_gain_i         = data[23:0];
            mspp_pkg::REG_GAIN_D:         m_gain_d         = data[23:0];
            mspp_pkg::REG_PWM_PERIOD:     m_pwm_period     = data[15:0];
            mspp_pkg::REG_DIR_ACTIVE_LOW: m_dir_active_low = data[0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_reset_values();
        send_tick(16'sd0, 32'sd0, pick_gap());
        send_tick(16'sh7FFF, 32'sh7FFF_FFFF, pick_gap());
        send_tick(16'sh8000, 32'sh8000_0000, pick_gap());
    endtask

    task automatic test_speed_saturation();
        wait_idle();
        write_reg(mspp_pkg::REG_SPEED_SCALE, 32'h007F_FFFF);
        write_reg(mspp_pkg::REG_GAIN_P, 32'd1);
        write_reg(mspp_pkg::REG_GAIN_I, 32'd0);
        write_reg(mspp_pkg::REG_GAIN_D, 32'd0);
        write_reg(mspp_pkg::REG_PWM_PERIOD, 32'hFFFF);
        write_reg(mspp_pkg::REG_DIR_ACTIVE_LOW, 32'd0);
        send_tick(16'sh7FFF, 32'sd0, pick_gap());
        send_tick(16'sh8000, 32'sd0, pick_gap());
        send_tick(16'sh8000, 32'sh7FFF_FFFF, pick_gap());
        send_tick(16'sh7FFF, 32'sh8000_0000, pick_gap());
        wait_idle();
        write_reg(mspp_pkg::REG_SPEED_SCALE, 32'h0080_0000);
        send_tick(16'sh7FFF, 32'sd0, pick_gap());
        send_tick(16'sh8000, 32'sd0, pick_gap());
    endtask

    task automatic test_drive_limits();
        wait_idle();
        write_reg(mspp_pkg::REG_SPEED_SCALE, 32'd1);
        write_reg(mspp_pkg::REG_GAIN_P, 32'hFF_FFFF);
        send_tick(16'sd0, 32'sd1000, pick_gap());
        send_tick(16'sd0, -32'sd1000, pick_gap());
        // zero drive keeps the last direction
        send_tick(16'sd5, 32'sd5, pick_gap());
        wait_idle();
        write_reg(mspp_pkg::REG_DIR_ACTIVE_LOW, 32'd1);
        send_tick(16'sd0, 32'sd1000, pick_gap());
        send_tick(16'sd0, 32'sd0, pick_gap());
        send_tick(16'sd0, -32'sd1, pick_gap());
        send_tick(16'sd0, 32'sd0, pick_gap());
        wait_idle();
        write_reg(mspp_pkg::REG_GAIN_P, 32'd65536);
        send_tick(16'sd0, 32'sd32768, pick_gap());
    endtask

    task automatic test_integral_clamp();
        wait_idle();
        write_reg(mspp_pkg::REG_SPEED_SCALE, 32'd0);
        write_reg(mspp_pkg::REG_GAIN_P, 32'd0);
        write_reg(mspp_pkg::REG_GAIN_I, 32'd65536);
        write_reg(mspp_pkg::REG_LOOP_PERIOD, 32'hFFFF);
        write_reg(mspp_pkg::REG_INTEGRAL_BOUND, 32'd1000);
        write_reg(mspp_pkg::REG_DIR_ACTIVE_LOW, 32'd0);
        send_tick(16'sd0, 32'sh7FFF_FFFF, pick_gap());
        send_tick(16'sd0, 32'sh8000_0000, pick_gap());
        wait_idle();
        write_reg(mspp_pkg::REG_INTEGRAL_BOUND, 32'd0);
        send_tick(16'sd0, 32'sd12345, pick_gap());
        wait_idle();
        write_reg(mspp_pkg::REG_INTEGRAL_BOUND, 32'h7FFF_FFFF);
        write_reg(mspp_pkg::REG_GAIN_D, 32'hFF_FFFF);
        send_tick(16'sd0, 32'sh8000_0000, pick_gap());
        send_tick(16'sd0, 32'sh7FFF_FFFF, pick_gap());
        wait_idle();
        write_reg(mspp_pkg::REG_LOOP_PERIOD, 32'd0);
        send_tick(16'sd0, 32'sd100, pick_gap());
    endtask

    task automatic test_random_traffic();
        int mode;
        logic signed [15:0] count;
        logic signed [31:0] target;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            no_gaps = (p == 3);
            if (p == 0)
            begin
                write_reg(mspp_pkg::REG_SPEED_SCALE, 32'h007F_FFFF);
                write_reg(mspp_pkg::REG_LOOP_PERIOD, 32'hFFFF);
                write_reg(mspp_pkg::REG_INTEGRAL_BOUND, 32'h7FFF_FFFF);
                write_reg(mspp_pkg::REG_GAIN_P, 32'hFF_FFFF);
                write_reg(mspp_pkg::REG_GAIN_I, 32'hFF_FFFF);
                write_reg(mspp_pkg::REG_GAIN_D, 32'hFF_FFFF);
                write_reg(mspp_pkg::REG_PWM_PERIOD, 32'hFFFF);
                write_reg(mspp_pkg::REG_DIR_ACTIVE_LOW, 32'd1);
            end
            else if (p == 1)
            begin
                write_reg(mspp_pkg::REG_SPEED_SCALE, 32'h0080_0000);
                write_reg(mspp_pkg::REG_LOOP_PERIOD, 32'd0);
                write_reg(mspp_pkg::REG_INTEGRAL_BOUND, 32'd0);
                write_reg(mspp_pkg::REG_GAIN_P, 32'd0);
                write_reg(mspp_pkg::REG_GAIN_I, 32'd0);
                write_reg(mspp_pkg::REG_GAIN_D, 32'd0);
                write_reg(mspp_pkg::REG_PWM_PERIOD, 32'd0);
                write_reg(mspp_pkg::REG_DIR_ACTIVE_LOW, 32'd0);
            end
            else
            begin
                // unused upper data bits carry noise
                write_reg(mspp_pkg::REG_SPEED_SCALE,
                          {8'($urandom()), 24'(signed_spread(24))});
                write_reg(mspp_pkg::REG_LOOP_PERIOD, {16'($urandom()), 16'($urandom())});
                write_reg(mspp_pkg::REG_INTEGRAL_BOUND, {1'($urandom()), 31'(spread(31))});
                write_reg(mspp_pkg::REG_GAIN_P, {8'($urandom()), 24'(spread(24))});
                write_reg(mspp_pkg::REG_GAIN_I, {8'($urandom()), 24'(spread(24))});
                write_reg(mspp_pkg::REG_GAIN_D, {8'($urandom()), 24'(spread(20))});
                write_reg(mspp_pkg::REG_PWM_PERIOD, {16'($urandom()), 16'($urandom())});
                write_reg(mspp_pkg::REG_DIR_ACTIVE_LOW, {31'($urandom()), 1'($urandom())});
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                mode = $urandom_range(0, 3);
                case (mode)
                    0:
                    begin
                        count  = 16'($urandom());
                        target = $urandom();
                    end
                    1:
                    begin
                        count  = 16'(signed_spread(16));
                        target = 32'(signed_spread(32));
                    end
                    default:
                    begin
                        // target close to the measured speed
                        count  = 16'(signed_spread(12));
                        target = 32'(clip32(clip32(longint'(count) * longint'(m_speed_scale))
                                            + signed_spread(20)));
                    end
                endcase
                send_tick(count, target, pick_gap());
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        rx_hold = HOLD_CYCLES;
        for (int n = 0; n < 20; n++)
            send_tick(16'($urandom()), $urandom(), 0);
    endtask

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (rx_hold > 0)
            begin
                stall = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_drive.size() == 0)
            begin
                $display("%0t: unexpected result word, compare %0d direction %0b speed %0d",
                         $time, pwm_compare, direction_level, measured_speed);
                mismatch_count++;
            end
            else
            begin
                exp_word = expected_drive.pop_front();
                if (pwm_compare !== exp_word.compare)
                begin
                    $display("%0t: pwm_compare expected %0d actual %0d",
                             $time, exp_word.compare, pwm_compare);
                    mismatch_count++;
                end
                if (direction_level !== exp_word.direction)
                begin
                    $display("%0t: direction_level expected %0b actual %0b",
                             $time, exp_word.direction, direction_level);
                    mismatch_count++;
                end
                if (measured_speed !== exp_word.speed)
                begin
                    $display("%0t: measured_speed expected %0d actual %0d",
                             $time, exp_word.speed, measured_speed);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("motor_speed_pid_pwm_core verification failed");
        $finish;
    end

    initial
    begin
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        encoder_count  = '0;
        speed_setpoint = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_speed_saturation();
        test_drive_limits();
        test_integral_clamp();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();
        if (expected_drive.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, expected_drive.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("motor_speed_pid_pwm_core verification clean");
        else
            $display("motor_speed_pid_pwm_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/mspp_pkg.sv
design/mspp_cfg.sv
design/mspp_mul.sv
design/mspp_ctrl.sv
design/motor_speed_pid_pwm_core.sv
design/mspp_checker.sv
tb/testbench.sv
